@@ rtl/core/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk_i, rstn_i, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define CHK_NEXT(label, clk_i, rstn_i, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/core/lie_pkg.sv @@
package lie_pkg;
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BYTE_TIME = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_LAT  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_JITTER    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOSS      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_QLIMIT    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DROP_OLD  = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OVERHEAD  = 3'd6;

  localparam logic [2:0] EV_ACCEPT  = 3'd0;
  localparam logic [2:0] EV_LOST    = 3'd1;
  localparam logic [2:0] EV_REFUSED = 3'd2;
  localparam logic [2:0] EV_EVICT   = 3'd3;
  localparam logic [2:0] EV_DELIVER = 3'd4;

  typedef enum logic [1:0] {
    OP_LOST,
    OP_REFUSE,
    OP_ENQUEUE,
    OP_TICK
  } op_t;

  typedef struct packed {
    logic [15:0] byte_time_q8;
    logic [23:0] base_latency_us;
    logic [23:0] jitter_scale_us;
    logic [16:0] loss_threshold;
    logic [2:0]  queue_limit;
    logic        drop_oldest;
    logic [15:0] overhead_bytes;
  } cfg_t;

  // Classified item passed from front to back; now_us sized at 64 (max TIME_BITS).
  typedef struct packed {
    op_t          op;
    logic [63:0]  now_us;
    logic [15:0]  tag;
    logic [16:0]  bytes;
    logic signed [15:0] normal_draw;
  } job_t;
endpackage

@@ rtl/core/lie_front.sv @@
module lie_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_cmd,
  input  logic [63:0]   in_now,
  input  logic [15:0]   in_tag,
  input  logic [15:0]   in_payload,
  input  logic [15:0]   in_loss_sample,
  input  logic [15:0]   in_normal_draw,
  input  lie_pkg::cfg_t cfg,
  output logic          job_valid,
  input  logic          job_ready,
  output lie_pkg::job_t job
);
  import lie_pkg::*;

  // two-entry queue between front and back
  job_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic wp_r, rp_r;
  job_t cls;
  logic push, pop;

  always_comb begin
    cls.now_us      = in_now;
    cls.tag         = in_tag;
    cls.bytes       = {1'b0, in_payload} + {1'b0, cfg.overhead_bytes};
    cls.normal_draw = $signed(in_normal_draw);
    priority if (in_cmd) cls.op = OP_TICK;
    else if ({1'b0, in_loss_sample} < cfg.loss_threshold) cls.op = OP_LOST;
    else cls.op = OP_ENQUEUE;  // full/refuse resolved by back with live count
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign job_valid = (cnt_r != 2'd0);
  assign pop       = job_valid && job_ready;
  assign job       = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cls;
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
    end
  end
endmodule

@@ rtl/core/lie_back.sv @@
module lie_back #(
  parameter int SLOT_COUNT = 4,
  parameter int TIME_BITS  = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lie_pkg::cfg_t        cfg,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  lie_pkg::job_t        job,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_event_res,
  output logic [15:0]          out_tag_out,
  output logic [16:0]          out_accounted_bytes,
  output logic [TIME_BITS-1:0] out_sojourn_us,
  output logic [2:0]           out_occupancy,
  output logic                 out_last,
  output logic                 out_none_ready
);
  import lie_pkg::*;

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);

  typedef enum logic [2:0] {S_IDLE, S_TX, S_LAT, S_WRITE, S_TICK, S_OUT} state_t;

  logic [15:0]          tag_m  [SLOT_COUNT];
  logic [16:0]          byt_m  [SLOT_COUNT];
  logic [TIME_BITS-1:0] enq_m  [SLOT_COUNT];
  logic [TIME_BITS-1:0] txe_m  [SLOT_COUNT];
  logic [TIME_BITS-1:0] dlv_m  [SLOT_COUNT];

  state_t state_r;
  job_t   job_r;
  logic [IW-1:0] head_r;
  logic [CW-1:0] cnt_r;
  logic [TIME_BITS-1:0] lft_r;
  logic [TIME_BITS-1:0] tx_r;
  logic [TIME_BITS-1:0] lat_r;
  logic [TIME_BITS-1:0] now_t;
  logic [CW-1:0] limit;
  logic [15:0] bt;
  logic [32:0] txprod;
  logic signed [40:0] jprod;
  logic signed [41:0] lsum;
  logic [IW-1:0] tail_idx, newest_idx, head_inc;
  logic [TIME_BITS-1:0] start_t;
  logic full;
  logic out_free, out_load;
  logic [2:0] ev_r;
  logic [15:0] otag_r;
  logic [16:0] obyt_r;
  logic [TIME_BITS-1:0] osoj_r;
  logic [2:0] occ_r;
  logic last_r, none_r, ov_r;

  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [CW-1:0] b);
    logic [IW+CW:0] s;
    s = {{(CW+1){1'b0}}, a} + {{(IW+1){1'b0}}, b};
    if (s >= (IW+CW+1)'(SLOT_COUNT)) s = s - (IW+CW+1)'(SLOT_COUNT);
    return s[IW-1:0];
  endfunction

  assign now_t = job_r.now_us[TIME_BITS-1:0];
  assign bt    = (cfg.byte_time_q8 == 16'd0) ? 16'd1 : cfg.byte_time_q8;
  assign txprod = job_r.bytes * bt;
  assign jprod  = job_r.normal_draw * $signed({1'b0, cfg.jitter_scale_us});
  assign lsum   = $signed({2'b0, cfg.base_latency_us, 12'd0}) + 42'(jprod);

  always_comb begin
    if (cfg.queue_limit == 3'd0) limit = CW'(1);
    else if ({29'd0, cfg.queue_limit} > SLOT_COUNT) limit = CW'(SLOT_COUNT);
    else limit = CW'(cfg.queue_limit);
  end
  assign full       = (cnt_r >= limit);
  assign head_inc   = wrap_add(head_r, CW'(1));
  assign tail_idx   = wrap_add(head_r, cnt_r);
  assign newest_idx = wrap_add(head_r, cnt_r - CW'(1));
  assign start_t    = (now_t > lft_r) ? now_t : lft_r;

  // result register may be reloaded once its current transfer is done
  assign out_free = !ov_r || out_ready;
  always_comb begin
    unique case (state_r)
      S_WRITE, S_TICK, S_OUT: out_load = out_free;
      default: out_load = 1'b0;
    endcase
  end

  assign job_ready = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_event_res = ev_r;
  assign out_tag_out = otag_r;
  assign out_accounted_bytes = obyt_r;
  assign out_sojourn_us = osoj_r;
  assign out_occupancy = occ_r;
  assign out_last = last_r;
  assign out_none_ready = none_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
      head_r <= '0;
      cnt_r <= '0;
      lft_r <= '0;
    end else begin
      ov_r <= out_load || (ov_r && !out_ready);
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            job_r <= job;
            unique case (job.op)
              OP_TICK: state_r <= S_TICK;
              OP_LOST, OP_REFUSE: state_r <= S_OUT;
              OP_ENQUEUE: state_r <= S_TX;
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_TX: begin
          // eviction report goes to the result register: wait until it is free
          if (out_free) begin
            tx_r <= TIME_BITS'(txprod[32:8]);
            if (full && !cfg.drop_oldest) begin
              job_r.op <= OP_REFUSE;
              state_r <= S_OUT;
            end else begin
              if (full) begin
                ev_r <= EV_EVICT;
                otag_r <= tag_m[head_r];
                obyt_r <= byt_m[head_r];
                head_r <= head_inc;
                cnt_r <= cnt_r - CW'(1);
                if (cnt_r > CW'(1) && txe_m[newest_idx] > now_t) lft_r <= txe_m[newest_idx];
                else lft_r <= now_t;
              end else begin
                ev_r <= EV_ACCEPT;
                otag_r <= job_r.tag;
                obyt_r <= job_r.bytes;
              end
              state_r <= S_LAT;
            end
          end
        end
        S_LAT: begin
          lat_r <= (lsum > 42'sd0) ? TIME_BITS'(lsum[41:12]) : '0;
          state_r <= S_WRITE;
        end
        S_WRITE: begin
          if (out_free) begin
            tag_m[tail_idx] <= job_r.tag;
            byt_m[tail_idx] <= job_r.bytes;
            enq_m[tail_idx] <= now_t;
            txe_m[tail_idx] <= start_t + tx_r;
            dlv_m[tail_idx] <= start_t + tx_r + lat_r;
            lft_r <= start_t + tx_r;
            cnt_r <= cnt_r + CW'(1);
            osoj_r <= '0;
            occ_r <= 3'(cnt_r + CW'(1));
            last_r <= 1'b1;
            none_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        S_TICK: begin
          if (out_free) begin
            none_r <= 1'b0;
            if (cnt_r != '0 && dlv_m[head_r] <= now_t) begin
              ev_r <= EV_DELIVER;
              otag_r <= tag_m[head_r];
              obyt_r <= byt_m[head_r];
              osoj_r <= now_t - enq_m[head_r];
              occ_r <= 3'(cnt_r - CW'(1));
              head_r <= head_inc;
              cnt_r <= cnt_r - CW'(1);
              last_r <= (cnt_r == CW'(1)) || (dlv_m[head_inc] > now_t);
              if ((cnt_r == CW'(1)) || (dlv_m[head_inc] > now_t)) state_r <= S_IDLE;
            end else begin
              ev_r <= EV_ACCEPT;
              otag_r <= '0;
              obyt_r <= '0;
              osoj_r <= '0;
              occ_r <= '0;
              last_r <= 1'b1;
              none_r <= 1'b1;
              state_r <= S_IDLE;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            ev_r <= (job_r.op == OP_LOST) ? EV_LOST : EV_REFUSED;
            otag_r <= job_r.tag;
            obyt_r <= job_r.bytes;
            osoj_r <= '0;
            occ_r <= 3'(cnt_r);
            last_r <= 1'b1;
            none_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/core/link_impairment_emulator_core.sv @@
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_ready   | cmd, now_us, tag, bytes, draws
// out     | output    | out_valid/out_ready | event, tag, bytes, sojourn, occupancy
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
// An arrival passes the front queue, transmit-time, latency and slot-write states
// before its result loads; a lost packet goes to the result state, a refused one
// via transmit time. A tick yields one result per cycle while output is free.
// The front end classifies loss and holds up to two items in its queue.
// rst_n is synchronous: empties the queue and restores register defaults.
// Output stalls hold the back end; the front queue keeps accepting until full.
module link_impairment_emulator_core #(
  parameter int SLOT_COUNT = 4,
  parameter int TIME_BITS  = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  input  logic [TIME_BITS-1:0] in_now_us,
  input  logic [15:0]          in_packet_tag,
  input  logic [15:0]          in_payload_bytes,
  input  logic [15:0]          in_loss_sample,
  input  logic signed [15:0]   in_normal_draw,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_event_res,
  output logic [15:0]          out_tag_out,
  output logic [16:0]          out_accounted_bytes,
  output logic [TIME_BITS-1:0] out_sojourn_us,
  output logic [2:0]           out_occupancy,
  output logic                 out_last,
  output logic                 out_none_ready,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [23:0]          cfg_data
);
  import lie_pkg::*;

  cfg_t cfg_r;
  job_t job;
  logic job_valid, job_ready;

  assign cfg_ready = 1'b1;

  // register file; writes are to land only while idle, a contract on the user that the block leaves unenforced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.byte_time_q8    <= 16'd512;
      cfg_r.base_latency_us <= 24'd25000;
      cfg_r.jitter_scale_us <= 24'd5000;
      cfg_r.loss_threshold  <= 17'd328;
      cfg_r.queue_limit     <= 3'd2;
      cfg_r.drop_oldest     <= 1'b1;
      cfg_r.overhead_bytes  <= 16'd96;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BYTE_TIME: cfg_r.byte_time_q8    <= cfg_data[15:0];
        CFG_BASE_LAT:  cfg_r.base_latency_us <= cfg_data;
        CFG_JITTER:    cfg_r.jitter_scale_us <= cfg_data;
        CFG_LOSS:      cfg_r.loss_threshold  <= cfg_data[16:0];
        CFG_QLIMIT:    cfg_r.queue_limit     <= cfg_data[2:0];
        CFG_DROP_OLD:  cfg_r.drop_oldest     <= cfg_data[0];
        CFG_OVERHEAD:  cfg_r.overhead_bytes  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  lie_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd,
    .in_now(64'(in_now_us)), .in_tag(in_packet_tag), .in_payload(in_payload_bytes),
    .in_loss_sample, .in_normal_draw(in_normal_draw), .cfg(cfg_r),
    .job_valid, .job_ready, .job
  );

  lie_back #(.SLOT_COUNT(SLOT_COUNT), .TIME_BITS(TIME_BITS)) u_back (
    .clk, .rst_n, .cfg(cfg_r), .job_valid, .job_ready, .job,
    .out_valid, .out_ready, .out_event_res, .out_tag_out, .out_accounted_bytes,
    .out_sojourn_us, .out_occupancy, .out_last, .out_none_ready
  );
endmodule

@@ rtl/core/lie_checker.sv @@
`include "assert_macros.svh"
module lie_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_event_res,
  input logic [15:0] out_tag_out,
  input logic [2:0]  out_occupancy,
  input logic        out_last,
  input logic        out_none_ready
);
  import lie_pkg::*;

  `CHK_IMPL(a_none_last, clk, rst_n, out_valid && out_none_ready, out_last, "empty tick not last")
  `CHK_IMPL(a_arr_last, clk, rst_n, out_valid && out_event_res != EV_DELIVER, out_last, "not last")
  `CHK_IMPL(a_occ_range, clk, rst_n, out_valid, out_occupancy <= 3'd4, "occupancy out of range")
  `CHK_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_tag_out), "stall")
endmodule

bind link_impairment_emulator_core lie_checker u_chk (
  .clk, .rst_n, .out_valid, .out_ready, .out_event_res, .out_tag_out, .out_occupancy,
  .out_last, .out_none_ready
);
